FILE: sv/rumble_motor_envelope_macros.svh
// Assertion macros for the rumble motor envelope block.
`ifndef RUMBLE_MOTOR_ENVELOPE_MACROS_SVH
`define RUMBLE_MOTOR_ENVELOPE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define RME_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rme: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define RME_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rme: next-cycle check failed");
`else
`define RME_ASSERT_IMP(name, ck, rn, ante, cons)
`define RME_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

FILE: sv/rme_pkg.sv
// Shared types and constants for the rumble motor envelope block.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int PORT_W  = 2;
    localparam int DUR_W   = 15;
    localparam int LVL_W   = 8;
    localparam int STR_W   = 3;
    localparam int FRAME_W = 32;
    localparam int MODE_W  = 2;
    localparam int STUP_W  = 3;
    localparam int ACC_W   = 16;
    localparam int PT_W    = 3;
    localparam int ERR_W   = 5;
    localparam int CUBE_W  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Remainder unit: 32-bit dividend, 8-bit divisor, four quotient bits per cycle
    localparam int DSR_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = FRAME_W / DIGIT_W;
    localparam int DCNT_W     = $clog2(NUM_DIGITS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUEUE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DECAY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SLIP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VIBE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd5;

    // Envelope modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DENS = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 2'd3;

    // Config reset values
    localparam logic [7:0] THRESH_RST  = 8'd70;
    localparam logic [2:0] STARTUP_RST = 3'd4;
    localparam logic [4:0] ERR_LIM_RST = 5'd30;
    localparam logic [7:0] RETRY_RST   = 8'd60;

    // Envelope constants
    localparam logic [ACC_W-1:0] ACC_ONE  = 16'h0100;
    localparam logic [ACC_W-1:0] ACC_BIAS = 16'd4;
    localparam logic [PT_W-1:0]  PT_ARM   = 3'd7;
    localparam logic [PT_W-1:0]  PT_MIN   = 3'd4;
    localparam logic [PT_W-1:0]  PT_FORCE = 3'd5;
    localparam logic [PT_W-1:0]  PT_PULSE = 3'd2;
    localparam logic [PT_W-1:0]  PER_SLIP = 3'd7;
    localparam logic [PT_W-1:0]  PER_ONE  = 3'd1;
    localparam logic [STR_W-1:0] VIBE_BASE = 3'd5;
    localparam logic [STR_W-1:0] VIBE_MAX  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_MAX  = 5'd31;
    localparam logic [15:0]      FIN_LIM  = 16'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQ,
        S_CUBE,
        S_PER_GO,
        S_PER_WAIT,
        S_RI_GO,
        S_RI_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        Q_NONE,
        Q_SHIFT,
        Q_WRITE,
        Q_DECAY,
        Q_CLEAR
    } q_op_t;

    typedef struct packed {
        q_op_t              op;
        logic [PORT_W-1:0]  port;
        logic [MODE_W-1:0]  wr_mode;
        logic [DUR_W-1:0]   wr_dur;
        logic [LVL_W-1:0]   wr_lvl;
        logic [LVL_W-1:0]   wr_dec;
    } q_ctl_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DUR_W-1:0]   dur;
        logic [LVL_W-1:0]   lvl;
        logic [LVL_W-1:0]   dec;
        logic               any;
    } q_stat_t;

endpackage
`default_nettype wire

FILE: sv/rumble_motor_envelope.sv
// Top level of the rumble motor envelope block: handshakes, sequencer, port state.
//
// Channel   Dir  Handshake            Beat contents
// input     in   in_valid / in_stall  cmd port duration level strength frame_count
//                                     motor_present drive_failed
// result    out  out_valid/out_stall  out_port drive_issued motor_on pak_active finished
// config    in   cfg_valid/cfg_ready  cfg_index cfg_data
//
// Non-tick beats and ticks to an unknown port go straight to write-back. A tick
// sends the frame counter twice through the shared remainder unit (pulse period,
// then retry interval), 8 digit steps each, plus the two-step level cube.
// One beat is in flight at a time; in_stall is high until it is written back.
// The result register decouples the sides: processing continues while a result
// waits, and only the write-back step holds if the previous result is untaken.
// Reset clears config to defaults, all port state and the queue valid flags.
`timescale 1ns / 1ps
`default_nettype none
`include "rumble_motor_envelope_macros.svh"
module rumble_motor_envelope #(
    parameter int NUM_PORTS   = 4,
    parameter int QUEUE_DEPTH = 3
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [rme_pkg::CMD_W-1:0]      cmd,
    input  wire logic [rme_pkg::PORT_W-1:0]     port,
    input  wire logic [rme_pkg::DUR_W-1:0]      duration,
    input  wire logic [rme_pkg::LVL_W-1:0]      level,
    input  wire logic [rme_pkg::STR_W-1:0]      strength,
    input  wire logic [rme_pkg::FRAME_W-1:0]    frame_count,
    input  wire logic                           motor_present,
    input  wire logic                           drive_failed,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [rme_pkg::PORT_W-1:0]          out_port,
    output logic                                drive_issued,
    output logic                                motor_on,
    output logic                                pak_active,
    output logic                                finished,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rme_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rme_pkg::*;

    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [PORT_W:0] NPORTS = (PORT_W + 1)'(NUM_PORTS);

    // ---------------- sequencer ----------------
    state_t state_reg;
    state_t state_next;

    // ---------------- config registers ----------------
    logic [7:0] thresh_reg;
    logic [2:0] startup_reg;
    logic [4:0] err_lim_reg;
    logic [7:0] retry_reg;

    // ---------------- latched beat ----------------
    logic [CMD_W-1:0]   cmd_reg;
    logic [PORT_W-1:0]  port_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [STR_W-1:0]   str_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               present_reg;
    logic               failed_reg;
    logic [PW-1:0]      pidx;
    logic               port_ok;
    logic               port_ok_in;

    // ---------------- per-port state ----------------
    logic [MODE_W-1:0]  mode_reg  [NUM_PORTS];
    logic [STUP_W-1:0]  stup_reg  [NUM_PORTS];
    logic [DUR_W-1:0]   dleft_reg [NUM_PORTS];
    logic [LVL_W-1:0]   clvl_reg  [NUM_PORTS];
    logic [LVL_W-1:0]   cdec_reg  [NUM_PORTS];
    logic [ACC_W-1:0]   acc_reg   [NUM_PORTS];
    logic [PT_W-1:0]    ptim_reg  [NUM_PORTS];
    logic [PT_W-1:0]    pper_reg  [NUM_PORTS];
    logic               act_reg   [NUM_PORTS];
    logic [ERR_W-1:0]   err_reg   [NUM_PORTS];

    // ---------------- tick working set ----------------
    logic [MODE_W-1:0]  wk_mode_reg;
    logic [STUP_W-1:0]  wk_stup_reg;
    logic [DUR_W-1:0]   wk_dur_reg;
    logic [LVL_W-1:0]   wk_lvl_reg;
    logic [LVL_W-1:0]   wk_lvl_dec_reg;
    logic [LVL_W-1:0]   wk_dec_reg;
    logic [ACC_W-1:0]   wk_acc_reg;
    logic [15:0]        sq_reg;
    logic [CUBE_W-1:0]  cube_reg;
    logic [23:0]        cube_full;
    logic               per_zero_reg;
    logic               ri_zero_reg;

    // load path (queue head or current envelope)
    logic               head_hit;
    logic [LVL_W-1:0]   load_lvl;
    logic [LVL_W-1:0]   load_dec;

    // queue and remainder unit
    q_ctl_t             q_ctl;
    q_stat_t            q_stat;
    logic               rem_start;
    logic               rem_sel_ri;
    logic [DSR_W-1:0]   rem_divisor;
    logic               rem_done;
    logic [DSR_W-1:0]   rem_val;
    logic [DSR_W-1:0]   per_div;
    logic [DSR_W-1:0]   ri_div;

    // write-back values
    logic               fin_go;
    logic [MODE_W-1:0]  n_mode;
    logic [STUP_W-1:0]  n_stup;
    logic [DUR_W-1:0]   n_dur;
    logic [LVL_W-1:0]   n_lvl;
    logic [LVL_W-1:0]   n_dec;
    logic [ACC_W-1:0]   n_acc;
    logic [PT_W-1:0]    n_ptim;
    logic [PT_W-1:0]    n_pper;
    logic               n_act;
    logic [ERR_W-1:0]   n_err;
    logic               r_issued;
    logic               r_motor;
    logic               r_fin;

    // result register
    logic               out_valid_reg;
    logic [PORT_W-1:0]  out_port_reg;
    logic               issued_reg;
    logic               motor_reg;
    logic               active_reg;
    logic               fin_reg;

    assign pidx       = port_reg[PW-1:0];
    assign port_ok    = {1'b0, port_reg} < NPORTS;
    assign port_ok_in = {1'b0, port} < NPORTS;
    assign fin_go     = !out_valid_reg || !out_stall;
    assign cfg_ready  = 1'b1;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= THRESH_RST;
            startup_reg <= STARTUP_RST;
            err_lim_reg <= ERR_LIM_RST;
            retry_reg   <= RETRY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESH:  thresh_reg  <= cfg_data;
                CFG_STARTUP: startup_reg <= cfg_data[2:0];
                CFG_ERR_LIM: err_lim_reg <= cfg_data[4:0];
                CFG_RETRY:   retry_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == CMD_TICK && port_ok_in) ? S_LOAD : S_FIN;
                end
            end
            S_LOAD:     state_next = S_SQ;
            S_SQ:       state_next = S_CUBE;
            S_CUBE:     state_next = S_PER_GO;
            S_PER_GO:   state_next = S_PER_WAIT;
            S_PER_WAIT: state_next = rem_done ? S_RI_GO : S_PER_WAIT;
            S_RI_GO:    state_next = S_RI_WAIT;
            S_RI_WAIT:  state_next = rem_done ? S_FIN : S_RI_WAIT;
            S_FIN:      state_next = fin_go ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        in_stall     = 1'b1;
        rem_start    = 1'b0;
        rem_sel_ri   = 1'b0;
        q_ctl.op     = Q_NONE;
        q_ctl.port   = port_reg;
        q_ctl.wr_mode = (lvl_reg > thresh_reg) ? MODE_CONT : MODE_DENS;
        q_ctl.wr_dur = dur_reg;
        q_ctl.wr_lvl = lvl_reg;
        q_ctl.wr_dec = (cmd_reg == CMD_QUEUE) ? '0 : lvl_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_LOAD:
            begin
                q_ctl.op = Q_SHIFT;
            end
            S_PER_GO:
            begin
                rem_start = 1'b1;
            end
            S_RI_GO:
            begin
                rem_start  = 1'b1;
                rem_sel_ri = 1'b1;
            end
            S_FIN:
            begin
                if (fin_go && port_ok)
                begin
                    case (cmd_reg)
                        CMD_QUEUE:  q_ctl.op = Q_WRITE;
                        CMD_DECAY:  q_ctl.op = Q_DECAY;
                        CMD_CANCEL: q_ctl.op = Q_CLEAR;
                        default:    q_ctl.op = Q_NONE;
                    endcase
                end
            end
            S_SQ, S_CUBE, S_PER_WAIT, S_RI_WAIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- beat capture ----------------
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg     <= cmd;
            port_reg    <= port;
            dur_reg     <= duration;
            lvl_reg     <= level;
            str_reg     <= strength;
            frame_reg   <= frame_count;
            present_reg <= motor_present;
            failed_reg  <= drive_failed;
        end
    end

    // ---------------- queue ----------------
    rme_queue #(
        .NUM_PORTS   (NUM_PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .stat  (q_stat)
    );

    // ---------------- load: queue head becomes the envelope ----------------
    assign head_hit = (q_stat.mode != MODE_NONE);
    assign load_lvl = head_hit ? q_stat.lvl : clvl_reg[pidx];
    assign load_dec = head_hit ? q_stat.dec : cdec_reg[pidx];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            wk_mode_reg    <= head_hit ? q_stat.mode : mode_reg[pidx];
            wk_stup_reg    <= head_hit ? startup_reg : stup_reg[pidx];
            wk_dur_reg     <= head_hit ? q_stat.dur : dleft_reg[pidx];
            wk_acc_reg     <= head_hit ? '0 : acc_reg[pidx];
            wk_lvl_reg     <= load_lvl;
            wk_dec_reg     <= load_dec;
            // decayed level, clamped at zero
            wk_lvl_dec_reg <= (load_lvl > load_dec) ? (load_lvl - load_dec) : '0;
        end
        // level cube in two multiplies, /512 by dropping low bits
        if (state_reg == S_SQ)
        begin
            sq_reg <= 16'(wk_lvl_dec_reg) * 16'(wk_lvl_dec_reg);
        end
        if (state_reg == S_CUBE)
        begin
            cube_reg <= cube_full[23:9];
        end
        if (state_reg == S_PER_WAIT && rem_done)
        begin
            per_zero_reg <= (rem_val == '0);
        end
        if (state_reg == S_RI_WAIT && rem_done)
        begin
            ri_zero_reg <= (rem_val == '0);
        end
    end

    assign cube_full = 24'(sq_reg) * 24'(wk_lvl_dec_reg);

    // ---------------- shared remainder unit ----------------
    // a zero period or interval counts as one
    assign per_div = (pper_reg[pidx] == '0) ? DSR_W'(PER_ONE) : DSR_W'(pper_reg[pidx]);
    assign ri_div  = (retry_reg == '0) ? DSR_W'(1) : retry_reg;
    assign rem_divisor = rem_sel_ri ? ri_div : per_div;

    rme_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (frame_reg),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .rem      (rem_val)
    );

    // ---------------- write-back and status ----------------
    always_comb
    begin
        logic             on;
        logic [PT_W-1:0]  armed;
        logic             q_empty;
        logic [15:0]      left_sum;
        n_mode   = mode_reg[pidx];
        n_stup   = stup_reg[pidx];
        n_dur    = dleft_reg[pidx];
        n_lvl    = clvl_reg[pidx];
        n_dec    = cdec_reg[pidx];
        n_acc    = acc_reg[pidx];
        n_ptim   = ptim_reg[pidx];
        n_pper   = pper_reg[pidx];
        n_act    = act_reg[pidx];
        n_err    = err_reg[pidx];
        r_issued = 1'b0;
        r_motor  = 1'b0;
        on       = 1'b0;
        q_empty  = !q_stat.any;
        // slip / vibrate arming: start at 7, never below 4
        armed    = (ptim_reg[pidx] == '0) ? PT_ARM : ptim_reg[pidx];
        if (armed < PT_MIN)
        begin
            armed = PT_MIN;
        end
        case (cmd_reg)
            CMD_TICK:
            begin
                n_mode = wk_mode_reg;
                n_stup = wk_stup_reg;
                n_dur  = wk_dur_reg;
                n_lvl  = wk_lvl_reg;
                n_dec  = wk_dec_reg;
                n_acc  = wk_acc_reg;
                if (wk_stup_reg != '0)
                begin
                    n_stup = wk_stup_reg - 1'b1;
                    on     = 1'b1;
                end
                else if (wk_dur_reg != '0)
                begin
                    n_dur = wk_dur_reg - 1'b1;
                    n_lvl = wk_lvl_dec_reg;
                    if (wk_mode_reg == MODE_CONT)
                    begin
                        on = 1'b1;
                    end
                    else if (wk_acc_reg >= ACC_ONE)
                    begin
                        n_acc = wk_acc_reg - ACC_ONE;
                        on    = 1'b1;
                    end
                    else
                    begin
                        n_acc = wk_acc_reg + ACC_W'(cube_reg) + ACC_BIAS;
                    end
                end
                else if (ptim_reg[pidx] >= PT_FORCE)
                begin
                    on = 1'b1;
                end
                else if (ptim_reg[pidx] >= PT_PULSE && per_zero_reg)
                begin
                    on = 1'b1;
                end
                if (ptim_reg[pidx] != '0)
                begin
                    n_ptim = ptim_reg[pidx] - 1'b1;
                end
                if (act_reg[pidx])
                begin
                    r_issued = 1'b1;
                    r_motor  = on;
                    if (failed_reg)
                    begin
                        n_err = (err_reg[pidx] == ERR_MAX) ? ERR_MAX : err_reg[pidx] + 1'b1;
                    end
                    else
                    begin
                        n_err = '0;
                    end
                    if (n_err >= err_lim_reg)
                    begin
                        n_act = 1'b0;
                    end
                end
                else if (ri_zero_reg)
                begin
                    n_act = present_reg;
                    n_err = '0;
                end
            end
            CMD_QUEUE:
            begin
                q_empty = 1'b0;
            end
            CMD_SLIP:
            begin
                n_ptim = armed;
                n_pper = PER_SLIP;
            end
            CMD_VIBE:
            begin
                n_ptim = armed;
                if (str_reg <= VIBE_MAX)
                begin
                    n_pper = VIBE_BASE - str_reg;
                end
            end
            CMD_CANCEL:
            begin
                n_act    = present_reg;
                r_issued = present_reg;
                q_empty  = 1'b1;
                n_dur    = '0;
                n_ptim   = '0;
            end
            default:
            begin
            end
        endcase
        left_sum = 16'(n_stup) + 16'(n_dur);
        r_fin    = (left_sum < FIN_LIM) && q_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                mode_reg[p]  <= MODE_NONE;
                stup_reg[p]  <= '0;
                dleft_reg[p] <= '0;
                clvl_reg[p]  <= '0;
                cdec_reg[p]  <= '0;
                acc_reg[p]   <= '0;
                ptim_reg[p]  <= '0;
                pper_reg[p]  <= PER_ONE;
                act_reg[p]   <= 1'b0;
                err_reg[p]   <= '0;
            end
        end
        else if (state_reg == S_FIN && fin_go && port_ok)
        begin
            mode_reg[pidx]  <= n_mode;
            stup_reg[pidx]  <= n_stup;
            dleft_reg[pidx] <= n_dur;
            clvl_reg[pidx]  <= n_lvl;
            cdec_reg[pidx]  <= n_dec;
            acc_reg[pidx]   <= n_acc;
            ptim_reg[pidx]  <= n_ptim;
            pper_reg[pidx]  <= n_pper;
            act_reg[pidx]   <= n_act;
            err_reg[pidx]   <= n_err;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FIN && fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && fin_go)
        begin
            // unknown port: report port only
            out_port_reg <= port_reg;
            issued_reg   <= port_ok && r_issued;
            motor_reg    <= port_ok && r_issued && r_motor;
            active_reg   <= port_ok && n_act;
            fin_reg      <= port_ok && r_fin;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_port     = out_port_reg;
    assign drive_issued = issued_reg;
    assign motor_on     = motor_reg;
    assign pak_active   = active_reg;
    assign finished     = fin_reg;

    // ---------------- checks ----------------
    `RME_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    `RME_ASSERT_IMP(a_rem_done_wait, clk, rst_n, rem_done, state_reg == S_PER_WAIT || state_reg == S_RI_WAIT)
    `RME_ASSERT_IMP(a_motor_issued, clk, rst_n, out_valid && motor_on, drive_issued)
    `RME_ASSERT_NXT(a_fin_idle, clk, rst_n, state_reg == S_FIN && fin_go, !in_stall && out_valid)

endmodule
`default_nettype wire

FILE: sv/rme_rem.sv
// Iterative remainder unit: frame counter modulo a small period, four bits a cycle.
`timescale 1ns / 1ps
`default_nettype none
module rme_rem (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rme_pkg::FRAME_W-1:0] dividend,
    input  wire logic [rme_pkg::DSR_W-1:0]   divisor,
    output logic                             done,
    output logic [rme_pkg::DSR_W-1:0]        rem
);
    import rme_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DCNT_W-1:0]    cnt_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     rem_next;
    logic [FRAME_W-1:0]   dvd_reg;
    logic [FRAME_W-1:0]   dvd_next;
    logic [DSR_W-1:0]     dsr_reg;

    // restoring steps, one per dividend bit
    always_comb
    begin
        logic [DSR_W:0]     t;
        logic [DSR_W-1:0]   r;
        logic [FRAME_W-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int k = 0; k < DIGIT_W; k++)
        begin
            t = {r, d[FRAME_W-1]};
            d = {d[FRAME_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg})
            begin
                t = t - {1'b0, dsr_reg};
            end
            r = t[DSR_W-1:0];
        end
        rem_next = r;
        dvd_next = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(NUM_DIGITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

FILE: sv/rme_queue.sv
// Per-port command queue: head read, shift, tail write, tail decay update, clear.
`timescale 1ns / 1ps
`default_nettype none
module rme_queue #(
    parameter int NUM_PORTS   = 4,
    parameter int QUEUE_DEPTH = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rme_pkg::q_ctl_t  ctl,
    output rme_pkg::q_stat_t      stat
);
    import rme_pkg::*;

    localparam int PW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int LAST = QUEUE_DEPTH - 1;

    logic [MODE_W-1:0] q_mode_reg [NUM_PORTS][QUEUE_DEPTH];
    logic [DUR_W-1:0]  q_dur_reg  [NUM_PORTS][QUEUE_DEPTH];
    logic [LVL_W-1:0]  q_lvl_reg  [NUM_PORTS][QUEUE_DEPTH];
    logic [LVL_W-1:0]  q_dec_reg  [NUM_PORTS][QUEUE_DEPTH];
    logic [PW-1:0]     pidx;

    assign pidx = ctl.port[PW-1:0];

    always_comb
    begin
        stat.mode = q_mode_reg[pidx][0];
        stat.dur  = q_dur_reg[pidx][0];
        stat.lvl  = q_lvl_reg[pidx][0];
        stat.dec  = q_dec_reg[pidx][0];
        stat.any  = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (q_mode_reg[pidx][i] != MODE_NONE)
            begin
                stat.any = 1'b1;
            end
        end
    end

    // mode doubles as the entry valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    q_mode_reg[p][i] <= MODE_NONE;
                end
            end
        end
        else
        begin
            unique case (ctl.op)
                Q_SHIFT:
                begin
                    for (int i = 0; i < LAST; i++)
                    begin
                        q_mode_reg[pidx][i] <= q_mode_reg[pidx][i+1];
                    end
                    q_mode_reg[pidx][LAST] <= MODE_NONE;
                end
                Q_WRITE:
                begin
                    q_mode_reg[pidx][LAST] <= ctl.wr_mode;
                end
                Q_CLEAR:
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        q_mode_reg[pidx][i] <= MODE_NONE;
                    end
                end
                Q_NONE, Q_DECAY:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            Q_SHIFT:
            begin
                for (int i = 0; i < LAST; i++)
                begin
                    q_dur_reg[pidx][i] <= q_dur_reg[pidx][i+1];
                    q_lvl_reg[pidx][i] <= q_lvl_reg[pidx][i+1];
                    q_dec_reg[pidx][i] <= q_dec_reg[pidx][i+1];
                end
            end
            Q_WRITE:
            begin
                q_dur_reg[pidx][LAST] <= ctl.wr_dur;
                q_lvl_reg[pidx][LAST] <= ctl.wr_lvl;
                q_dec_reg[pidx][LAST] <= ctl.wr_dec;
            end
            Q_DECAY:
            begin
                q_dec_reg[pidx][LAST] <= ctl.wr_dec;
            end
            Q_NONE, Q_CLEAR:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire
